[rtl/antialiased_capsule_blend_top_macros.svh]
// Assertion helpers for the capsule blend top-level RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ANTIALIASED_CAPSULE_BLEND_TOP_MACROS_SVH
`define ANTIALIASED_CAPSULE_BLEND_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACB_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/acb_pkg.sv]
`timescale 1ns / 1ps
package acb_pkg;

	// Field and coordinate widths.
	localparam int PIX_W           = 12;
	localparam int CH_W            = 8;
	localparam int RGB_W           = 3 * CH_W;
	localparam int COORD_INT_BITS  = 12;
	localparam int COORD_FRAC_BITS = 4;
	localparam int CW              = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int RW              = 12;
	localparam int CFG_IDX_W       = 3;

	// Internal datapath widths.
	localparam int PW    = PIX_W + COORD_FRAC_BITS;
	localparam int WW    = ((PW > CW) ? PW : CW) + 2;
	localparam int VW    = CW + 1;
	localparam int PRW   = WW + VW;
	localparam int DOTW  = PRW + 1;
	localparam int VSQW  = 2 * VW;
	localparam int LENW  = VSQW;
	localparam int T_BITS = 16;
	localparam int TW    = T_BITS + 1;
	localparam int TVW   = TW + 1 + VW;
	localparam int EW    = (((WW + T_BITS) > TVW) ? (WW + T_BITS) : TVW) + 1;
	localparam int MW    = 31;
	localparam int SQMW  = 2 * MW;
	localparam int D2W   = SQMW + 1;
	localparam int RSW   = RW + T_BITS - COORD_FRAC_BITS;
	localparam int RIW   = RSW + 2;
	localparam int RSQW  = 2 * RIW;
	localparam int NW    = RSQW + 10;
	localparam int AQ_BITS = 9;
	localparam int MIXW  = 2 * CH_W;

	// Constants of the arithmetic.
	localparam logic [TW-1:0]  T_ONE    = TW'(1) << T_BITS;
	localparam logic [MW-1:0]  DIST_SAT = MW'(1) << (MW - 1);
	localparam logic [RIW-1:0] QUARTER3 = RIW'(3) << (T_BITS - 2);
	localparam logic [COORD_FRAC_BITS-1:0] PIX_HALF =
		COORD_FRAC_BITS'(1) << (COORD_FRAC_BITS - 1);
	localparam int ROUND_E = 1 << (COORD_FRAC_BITS - 1);
	localparam logic [CH_W-1:0] CH_MAX    = '1;
	localparam logic [CH_W-1:0] ROUND_255 = CH_W'(127);
	localparam logic [RW-1:0]   RAD_RST   = RW'(16);

	// Pipeline stage numbers, counted from the input side.
	localparam int ST_S1   = 1;
	localparam int ST_S2   = 2;
	localparam int ST_S3   = 3;
	localparam int ST_S4   = 4;
	localparam int ST_TDIV = 5;
	localparam int ST_TMUL = ST_TDIV + T_BITS;
	localparam int ST_ERR  = ST_TMUL + 1;
	localparam int ST_MAG  = ST_ERR + 1;
	localparam int ST_SQ   = ST_MAG + 1;
	localparam int ST_D2   = ST_SQ + 1;
	localparam int ST_ACLS = ST_D2 + 1;
	localparam int ST_NUM  = ST_ACLS + 1;
	localparam int ST_ADIV = ST_NUM + 1;
	localparam int ST_MIX  = ST_ADIV + AQ_BITS;
	localparam int ST_OUT  = ST_MIX + 1;
	localparam int N_ST    = ST_OUT;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X,
		CFG_START_Y,
		CFG_END_X,
		CFG_END_Y,
		CFG_RADIUS,
		CFG_FILL_RGB
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic [CH_W-1:0]  dst_red;
		logic [CH_W-1:0]  dst_green;
		logic [CH_W-1:0]  dst_blue;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] coverage_alpha;
	} res_t;

	typedef enum logic [1:0] {TM_ZERO, TM_ONE, TM_DIV} tmode_t;
	typedef enum logic [1:0] {AM_FULL, AM_NONE, AM_DIV} amode_t;

	typedef struct packed {
		logic signed [WW-1:0] wx;
		logic signed [WW-1:0] wy;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic [RGB_W-1:0]     dst;
	} geo_t;

	typedef struct packed {
		tmode_t            mode;
		logic [LENW-1:0]   rem;
		logic [LENW-1:0]   len;
		logic [T_BITS-1:0] q;
		geo_t              g;
	} tdv_t;

	typedef struct packed {
		amode_t             mode;
		logic [NW-1:0]      rem;
		logic [RSQW:0]      dd;
		logic [AQ_BITS-1:0] q;
		logic [RGB_W-1:0]   dst;
	} adv_t;

	typedef struct packed {
		logic ld_mix;
		logic ld_out;
	} blend_ctl_t;

endpackage

[rtl/acb_blend.sv]
`timescale 1ns / 1ps
module acb_blend (
	input  logic                     clk,
	input  acb_pkg::blend_ctl_t      ctl,
	input  logic [acb_pkg::CH_W-1:0] alpha,
	input  logic [acb_pkg::RGB_W-1:0] dst,
	input  logic [acb_pkg::RGB_W-1:0] fill,
	output acb_pkg::res_t            res
);
	import acb_pkg::*;

	// Exact divide by 255 for values below 65280.
	function automatic logic [CH_W-1:0] div255(logic [MIXW-1:0] v);
		logic [MIXW:0] s;
		s = {1'b0, v} + (MIXW+1)'(v >> CH_W) + (MIXW+1)'(1);
		return s[MIXW-1:CH_W];
	endfunction

	logic [MIXW-1:0] mix_c [3];
	logic [MIXW-1:0] mix_s14 [3];
	logic [CH_W-1:0] alpha_s14;
	res_t            res_s15;

	// Weighted sum of destination and fill per channel, with rounding term.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix_c[c] = {{CH_W{1'b0}}, dst[RGB_W-1-c*CH_W -: CH_W]} *
				{{CH_W{1'b0}}, CH_MAX - alpha}
				+ {{CH_W{1'b0}}, fill[RGB_W-1-c*CH_W -: CH_W]} * {{CH_W{1'b0}}, alpha}
				+ {{CH_W{1'b0}}, ROUND_255};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_mix) begin
			for (int c = 0; c < 3; c++) begin
				mix_s14[c] <= mix_c[c];
			end
			alpha_s14 <= alpha;
		end
	end

	// Output register: normalize each channel.
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			res_s15.out_red        <= div255(mix_s14[0]);
			res_s15.out_green      <= div255(mix_s14[1]);
			res_s15.out_blue       <= div255(mix_s14[2]);
			res_s15.coverage_alpha <= alpha_s14;
		end
	end

	assign res = res_s15;

endmodule

[rtl/antialiased_capsule_blend_top.sv]
// Blends an anti-aliased capsule (a segment thickened by a radius) over one
// destination pixel per transaction. The block accepts one pixel per clock and
// returns one blended pixel per clock while the output is not stalled. The
// projection divider resolves one of 16 quotient bits per stage, and
// the coverage divider resolves one of 9 bits per stage. Stalls propagate
// stage by stage, so empty stages keep filling while a finished result waits
// at the output. The user must write configuration only while no pixel is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "antialiased_capsule_blend_top_macros.svh"
module antialiased_capsule_blend_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  acb_pkg::pix_t                 pix,
	output logic                          res_valid,
	input  logic                          res_stall,
	output acb_pkg::res_t                 res,
	input  logic                          cfg_we,
	input  logic [acb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acb_pkg::RGB_W-1:0]     cfg_data
);
	import acb_pkg::*;

	// One restoring step of the projection divider.
	function automatic tdv_t tdiv_step(tdv_t d);
		logic [LENW:0] r2;
		tdv_t          o;
		o  = d;
		r2 = {d.rem, 1'b0};
		if (r2 >= {1'b0, d.len}) begin
			o.rem = LENW'(r2 - {1'b0, d.len});
			o.q   = {d.q[T_BITS-2:0], 1'b1};
		end else begin
			o.rem = r2[LENW-1:0];
			o.q   = {d.q[T_BITS-2:0], 1'b0};
		end
		return o;
	endfunction

	// One restoring step of the coverage divider, at quotient weight 2^k.
	function automatic adv_t adiv_step(adv_t d, int unsigned k);
		logic [NW-1:0] sh;
		adv_t          o;
		o  = d;
		sh = NW'(d.dd) << k;
		if (d.rem >= sh) begin
			o.rem = d.rem - sh;
			o.q   = {d.q[AQ_BITS-2:0], 1'b1};
		end else begin
			o.q   = {d.q[AQ_BITS-2:0], 1'b0};
		end
		return o;
	endfunction

	// Rounded, saturated magnitude of an axis offset.
	function automatic logic [MW-1:0] axis_mag(logic signed [EW-1:0] e);
		logic [EW-1:0] m;
		logic [EW-1:0] r;
		m = e[EW-1] ? EW'(-e) : EW'(e);
		r = (m + EW'(ROUND_E)) >> COORD_FRAC_BITS;
		return (r > EW'(DIST_SAT)) ? DIST_SAT : r[MW-1:0];
	endfunction

	// Configuration registers.
	logic [CW-1:0]    sx_q, sy_q, ex_q, ey_q;
	logic [RW-1:0]    rad_q;
	logic [RGB_W-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q   <= '0;
			sy_q   <= '0;
			ex_q   <= '0;
			ey_q   <= '0;
			rad_q  <= RAD_RST;
			fill_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_START_X:  sx_q   <= cfg_data[CW-1:0];
				CFG_START_Y:  sy_q   <= cfg_data[CW-1:0];
				CFG_END_X:    ex_q   <= cfg_data[CW-1:0];
				CFG_END_Y:    ey_q   <= cfg_data[CW-1:0];
				CFG_RADIUS:   rad_q  <= cfg_data[RW-1:0];
				CFG_FILL_RGB: fill_q <= cfg_data[RGB_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits and the per-stage load enables.
	logic [N_ST:1]   v_q;
	logic [N_ST:1]   v_prev;
	logic [N_ST+1:1] en;

	assign v_prev = {v_q[N_ST-1:1], pix_valid};

	always_comb begin
		en[N_ST+1] = !res_stall;
		for (int k = N_ST; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= N_ST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_prev[k];
				end
			end
		end
	end

	assign pix_stall = !en[ST_S1];
	assign res_valid = v_q[ST_OUT];

	// Stage 1: pixel center relative to the segment start, and segment vector.
	logic [PW-1:0] px_c, py_c;
	geo_t          geo_s1;

	assign px_c = {pix.pixel_x, PIX_HALF};
	assign py_c = {pix.pixel_y, PIX_HALF};

	always_ff @(posedge clk) begin
		if (en[ST_S1]) begin
			geo_s1.wx  <= $signed({{(WW-PW){1'b0}}, px_c}) -
				$signed({{(WW-CW){sx_q[CW-1]}}, sx_q});
			geo_s1.wy  <= $signed({{(WW-PW){1'b0}}, py_c}) -
				$signed({{(WW-CW){sy_q[CW-1]}}, sy_q});
			geo_s1.vx  <= $signed({ex_q[CW-1], ex_q}) - $signed({sx_q[CW-1], sx_q});
			geo_s1.vy  <= $signed({ey_q[CW-1], ey_q}) - $signed({sy_q[CW-1], sy_q});
			geo_s1.dst <= {pix.dst_red, pix.dst_green, pix.dst_blue};
		end
	end

	// Stage 2: products for the dot product and the squared length.
	logic signed [PRW-1:0]  pwx_s2, pwy_s2;
	logic signed [VSQW-1:0] pvx_s2, pvy_s2;
	geo_t                   geo_s2;

	always_ff @(posedge clk) begin
		if (en[ST_S2]) begin
			pwx_s2 <= geo_s1.wx * geo_s1.vx;
			pwy_s2 <= geo_s1.wy * geo_s1.vy;
			pvx_s2 <= geo_s1.vx * geo_s1.vx;
			pvy_s2 <= geo_s1.vy * geo_s1.vy;
			geo_s2 <= geo_s1;
		end
	end

	// Stage 3: dot product and squared length.
	logic signed [DOTW-1:0] dot_s3;
	logic [LENW-1:0]        len_s3;
	geo_t                   geo_s3;

	always_ff @(posedge clk) begin
		if (en[ST_S3]) begin
			dot_s3 <= DOTW'(pwx_s2) + DOTW'(pwy_s2);
			len_s3 <= $unsigned(pvx_s2 + pvy_s2);
			geo_s3 <= geo_s2;
		end
	end

	// Stage 4: decide whether the projection is clamped or must be divided.
	tdv_t tdv_c;
	tdv_t tdv_s4;

	always_comb begin
		tdv_c.rem = dot_s3[LENW-1:0];
		tdv_c.len = len_s3;
		tdv_c.q   = '0;
		tdv_c.g   = geo_s3;
		priority if (len_s3 == '0 || dot_s3 <= 0) begin
			tdv_c.mode = TM_ZERO;
		end else if (dot_s3 >= $signed({{(DOTW-LENW){1'b0}}, len_s3})) begin
			tdv_c.mode = TM_ONE;
		end else begin
			tdv_c.mode = TM_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_S4]) begin
			tdv_s4 <= tdv_c;
		end
	end

	// Stage 5: projection divider, one quotient bit per stage.
	tdv_t tdv_s5 [T_BITS];

	for (genvar i = 0; i < T_BITS; i++) begin : g_tdiv
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[ST_TDIV+i]) begin
					tdv_s5[i] <= tdiv_step(tdv_s4);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[ST_TDIV+i]) begin
					tdv_s5[i] <= tdiv_step(tdv_s5[i-1]);
				end
			end
		end
	end

	// Stage 6: clamped parameter times the segment vector.
	tdv_t                  tdv_last;
	logic [TW-1:0]         t_c;
	logic [TW-1:0]         t_s6;
	logic signed [TVW-1:0] tvx_s6, tvy_s6;
	geo_t                  geo_s6;

	assign tdv_last = tdv_s5[T_BITS-1];

	always_comb begin
		unique case (tdv_last.mode)
			TM_ZERO: t_c = '0;
			TM_ONE:  t_c = T_ONE;
			TM_DIV:  t_c = {1'b0, tdv_last.q};
			default: t_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_TMUL]) begin
			t_s6   <= t_c;
			tvx_s6 <= $signed({1'b0, t_c}) * tdv_last.g.vx;
			tvy_s6 <= $signed({1'b0, t_c}) * tdv_last.g.vy;
			geo_s6 <= tdv_last.g;
		end
	end

	// Stage 7: offset from the closest point on the segment.
	logic signed [EW-1:0] ex_s7, ey_s7;
	logic [RGB_W-1:0]     dst_s7;

	always_ff @(posedge clk) begin
		if (en[ST_ERR]) begin
			ex_s7  <= EW'($signed({geo_s6.wx, {T_BITS{1'b0}}})) - EW'(tvx_s6);
			ey_s7  <= EW'($signed({geo_s6.wy, {T_BITS{1'b0}}})) - EW'(tvy_s6);
			dst_s7 <= geo_s6.dst;
		end
	end

	// Stage 8: rounded, saturated offset magnitudes.
	logic [MW-1:0]    mx_s8, my_s8;
	logic [RGB_W-1:0] dst_s8;

	always_ff @(posedge clk) begin
		if (en[ST_MAG]) begin
			mx_s8  <= axis_mag(ex_s7);
			my_s8  <= axis_mag(ey_s7);
			dst_s8 <= dst_s7;
		end
	end

	// Stage 9: squared offsets and the squared inner and outer radii.
	logic signed [RIW-1:0] inner_c, outer_c;
	logic [SQMW-1:0]       mx2_s9, my2_s9;
	logic [RSQW-1:0]       in2_s9, out2_s9;
	logic [RGB_W-1:0]      dst_s9;

	assign inner_c = $signed({2'b00, rad_q, {(T_BITS-COORD_FRAC_BITS){1'b0}}}) -
		$signed(QUARTER3);
	assign outer_c = $signed({2'b00, rad_q, {(T_BITS-COORD_FRAC_BITS){1'b0}}}) +
		$signed(QUARTER3);

	always_ff @(posedge clk) begin
		if (en[ST_SQ]) begin
			mx2_s9  <= mx_s8 * mx_s8;
			my2_s9  <= my_s8 * my_s8;
			in2_s9  <= inner_c * inner_c;
			out2_s9 <= outer_c * outer_c;
			dst_s9  <= dst_s8;
		end
	end

	// Stage 10: squared distance.
	logic [D2W-1:0]   d2_s10;
	logic [RSQW-1:0]  in2_s10, out2_s10;
	logic [RGB_W-1:0] dst_s10;

	always_ff @(posedge clk) begin
		if (en[ST_D2]) begin
			d2_s10   <= D2W'(mx2_s9) + D2W'(my2_s9);
			in2_s10  <= in2_s9;
			out2_s10 <= out2_s9;
			dst_s10  <= dst_s9;
		end
	end

	// Stage 11: fully inside, fully outside, or on the soft edge.
	amode_t           am_c;
	amode_t           am_s11;
	logic [RSQW-1:0]  diff_s11, den_s11;
	logic [RGB_W-1:0] dst_s11;

	always_comb begin
		priority if (d2_s10 <= D2W'(in2_s10)) begin
			am_c = AM_FULL;
		end else if (d2_s10 >= D2W'(out2_s10) || out2_s10 <= in2_s10) begin
			am_c = AM_NONE;
		end else begin
			am_c = AM_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_ACLS]) begin
			am_s11   <= am_c;
			diff_s11 <= RSQW'(D2W'(out2_s10) - d2_s10);
			den_s11  <= out2_s10 - in2_s10;
			dst_s11  <= dst_s10;
		end
	end

	// Stage 12: dividend (outer^2 - d2) * 510 + den and divisor 2 * den.
	adv_t adv_s12;

	always_ff @(posedge clk) begin
		if (en[ST_NUM]) begin
			adv_s12.mode <= am_s11;
			adv_s12.rem  <= (NW'(diff_s11) << 9) - (NW'(diff_s11) << 1) + NW'(den_s11);
			adv_s12.dd   <= {den_s11, 1'b0};
			adv_s12.q    <= '0;
			adv_s12.dst  <= dst_s11;
		end
	end

	// Stage 13: coverage divider, most significant quotient bit first.
	adv_t adv_s13 [AQ_BITS];

	for (genvar i = 0; i < AQ_BITS; i++) begin : g_adiv
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[ST_ADIV+i]) begin
					adv_s13[i] <= adiv_step(adv_s12, AQ_BITS - 1 - i);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[ST_ADIV+i]) begin
					adv_s13[i] <= adiv_step(adv_s13[i-1], AQ_BITS - 1 - i);
				end
			end
		end
	end

	// Final alpha, then the color mix and output register.
	adv_t            adv_last;
	logic [CH_W-1:0] alpha_c;
	blend_ctl_t      blend_ctl;

	assign adv_last = adv_s13[AQ_BITS-1];

	always_comb begin
		unique case (adv_last.mode)
			AM_FULL: alpha_c = CH_MAX;
			AM_NONE: alpha_c = '0;
			AM_DIV:  alpha_c = (adv_last.q > AQ_BITS'(CH_MAX)) ? CH_MAX :
				adv_last.q[CH_W-1:0];
			default: alpha_c = '0;
		endcase
	end

	assign blend_ctl.ld_mix = en[ST_MIX];
	assign blend_ctl.ld_out = en[ST_OUT];

	acb_blend u_blend (
		.clk   (clk),
		.ctl   (blend_ctl),
		.alpha (alpha_c),
		.dst   (adv_last.dst),
		.fill  (fill_q),
		.res   (res)
	);

	// The input only stalls when the whole pipeline is backed up to a held result.
	`ACB_ASSERT_NOW(a_stall_full, pix_stall, res_valid && v_q[ST_S1],
		"input stalled while the pipeline has room")
	// The clamped projection parameter never exceeds one.
	`ACB_ASSERT_NOW(a_t_range, v_q[ST_TMUL], t_s6 <= T_ONE,
		"projection parameter out of range")
	// The coverage quotient fits in eight bits.
	`ACB_ASSERT_NOW(a_alpha_q, v_q[ST_MIX-1] && adv_last.mode == AM_DIV,
		adv_last.q <= AQ_BITS'(CH_MAX), "coverage quotient above 255")
	// A held stage 6 keeps its transaction.
	`ACB_ASSERT_NEXT(a_hold_tmul, v_q[ST_TMUL] && !en[ST_TMUL+1], v_q[ST_TMUL],
		"transaction lost in a held stage")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
	import acb_pkg::*;

	localparam int LATENCY = 38;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RGB_W-1:0] cfg_data = '0;

	// Shadow copy of the configuration registers.
	logic signed [CW-1:0] seg_ax, seg_ay, seg_bx, seg_by;
	logic [RW-1:0] seg_radius;
	logic [RGB_W-1:0] seg_fill;

	res_t blend_queue[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit sender_idling = 1'b1;
	bit receiver_idling = 1'b1;
	bit hold_output = 1'b0;
	int hold_cycles = 0;
	int stall_left = 0;

	antialiased_capsule_blend_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Rounds an offset magnitude to 16 fraction bits and saturates it.
	function automatic longint offset_mag(longint e);
		longint m;
		m = (e < 0) ? -e : e;
		m = (m + (1 << (COORD_FRAC_BITS - 1))) >>> COORD_FRAC_BITS;
		return (m > (64'sd1 << 30)) ? (64'sd1 << 30) : m;
	endfunction

	function automatic logic [7:0] mix_channel(int d, int c, int a);
		return 8'((d * (255 - a) + c * a + 127) / 255);
	endfunction

	// Computes the blended pixel for the current capsule settings.
	function automatic res_t capsule_blend(pix_t p);
		longint ax, ay, vx, vy, wx, wy, len, dot, t, rem, mx, my;
		longint unsigned d2, in2, out2, den, q;
		longint inner, outer, r16;
		int a;
		res_t r;
		ax = seg_ax;
		ay = seg_ay;
		vx = longint'(seg_bx) - ax;
		vy = longint'(seg_by) - ay;
		wx = (longint'(p.pixel_x) << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1)) - ax;
		wy = (longint'(p.pixel_y) << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1)) - ay;
		len = vx * vx + vy * vy;
		dot = wx * vx + wy * vy;
		t = 0;
		if (len > 0 && dot > 0) begin
			if (dot >= len) begin
				t = 65536;
			end else begin
				rem = dot;
				for (int i = 0; i < 16; i++) begin
					rem = rem << 1;
					t = t << 1;
					if (rem >= len) begin
						rem -= len;
						t |= 1;
					end
				end
			end
		end
		mx = offset_mag(wx * 65536 - t * vx);
		my = offset_mag(wy * 65536 - t * vy);
		d2 = mx * mx + my * my;
		r16 = longint'(seg_radius) << (16 - COORD_FRAC_BITS);
		inner = r16 - 49152;
		outer = r16 + 49152;
		in2 = inner * inner;
		out2 = outer * outer;
		if (d2 <= in2) begin
			a = 255;
		end else if (d2 >= out2 || out2 <= in2) begin
			a = 0;
		end else begin
			den = out2 - in2;
			q = ((out2 - d2) * 510 + den) / (2 * den);
			a = (q > 255) ? 255 : int'(q);
		end
		r.out_red = mix_channel(p.dst_red, seg_fill[23:16], a);
		r.out_green = mix_channel(p.dst_green, seg_fill[15:8], a);
		r.out_blue = mix_channel(p.dst_blue, seg_fill[7:0], a);
		r.coverage_alpha = 8'(a);
		return r;
	endfunction

	// Writes one register while the block is idle and mirrors it locally.
	task automatic write_reg(cfg_reg_t idx, logic [RGB_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_START_X: seg_ax = val[CW-1:0];
			CFG_START_Y: seg_ay = val[CW-1:0];
			CFG_END_X: seg_bx = val[CW-1:0];
			CFG_END_Y: seg_by = val[CW-1:0];
			CFG_RADIUS: seg_radius = val[RW-1:0];
			CFG_FILL_RGB: seg_fill = val;
			default: ;
		endcase
	endtask

	// Waits until every pending result has been returned, then lets the pipe drain.
	task automatic drain_pipe();
		pix_valid <= 1'b0;
		while (blend_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_capsule(int sx, int sy, int ex, int ey, int rad, int rgb);
		drain_pipe();
		write_reg(CFG_START_X, RGB_W'(sx));
		write_reg(CFG_START_Y, RGB_W'(sy));
		write_reg(CFG_END_X, RGB_W'(ex));
		write_reg(CFG_END_Y, RGB_W'(ey));
		write_reg(CFG_RADIUS, RGB_W'(rad));
		write_reg(CFG_FILL_RGB, RGB_W'(rgb));
	endtask

	// Offers one pixel, when idling sometimes after a random gap with valid low, and holds
	// it until the block takes it. Valid stays high after it is taken so that the
	// next pixel can follow directly; the caller drops it before other pauses.
	task automatic send_pixel(pix_t p);
		if (sender_idling && $urandom_range(0, 4) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		blend_queue.push_back(capsule_blend(p));
	endtask

	function automatic pix_t rand_pixel_near(int cx, int cy, int spread);
		pix_t p;
		p.pixel_x = 12'(cx + $urandom_range(0, 2 * spread) - spread);
		p.pixel_y = 12'(cy + $urandom_range(0, 2 * spread) - spread);
		p.dst_red = 8'($urandom);
		p.dst_green = 8'($urandom);
		p.dst_blue = 8'($urandom);
		return p;
	endfunction

	function automatic pix_t make_pixel(int x, int y, int r, int g, int b);
		pix_t p;
		p.pixel_x = 12'(x);
		p.pixel_y = 12'(y);
		p.dst_red = 8'(r);
		p.dst_green = 8'(g);
		p.dst_blue = 8'(b);
		return p;
	endfunction

	// Reset-value capsule, extremes of the pixel fields.
	task automatic test_reset_disc();
		send_pixel(make_pixel(0, 0, 0, 0, 0));
		send_pixel(make_pixel(1, 0, 255, 255, 255));
		send_pixel(make_pixel(4095, 4095, 255, 0, 170));
		send_pixel(make_pixel(0, 1, 85, 255, 0));
	endtask

	// Directed edge cases: thin radius, zero radius, far pixels, endpoints.
	task automatic test_directed();
		set_capsule(10 * 16, 10 * 16, 30 * 16, 20 * 16, 48, 24'hFF8000);
		send_pixel(make_pixel(10, 10, 0, 0, 255));
		send_pixel(make_pixel(20, 15, 0, 0, 255));
		send_pixel(make_pixel(20, 17, 0, 0, 255));
		send_pixel(make_pixel(31, 21, 0, 0, 255));
		send_pixel(make_pixel(8, 8, 0, 0, 255));
		send_pixel(make_pixel(2000, 3000, 12, 34, 56));
		set_capsule(100, 100, 100, 100, 4, 24'h00FF00);
		send_pixel(make_pixel(6, 6, 200, 10, 30));
		send_pixel(make_pixel(5, 6, 200, 10, 30));
		set_capsule(100, 100, 300, 100, 0, 24'hFFFFFF);
		send_pixel(make_pixel(10, 6, 1, 2, 3));
		send_pixel(make_pixel(12, 7, 1, 2, 3));
		set_capsule(-32768, -32768, 32767, 32767, 4095, 24'h123456);
		send_pixel(make_pixel(0, 0, 9, 9, 9));
		send_pixel(make_pixel(4095, 0, 9, 9, 9));
		send_pixel(make_pixel(4095, 4095, 9, 9, 9));
		set_capsule(32767, -32768, -32768, 32767, 0, 24'hFFFFFF);
		send_pixel(make_pixel(0, 4095, 250, 250, 250));
		send_pixel(make_pixel(2048, 2047, 250, 250, 250));
	endtask

	// Random capsules with pixels clustered around them, plus scattered noise.
	task automatic test_random_capsules();
		int sx, sy, ex, ey, cx, cy;
		for (int c = 0; c < 30; c++) begin
			sx = $urandom_range(0, 200 * 16);
			sy = $urandom_range(0, 200 * 16);
			ex = sx + $urandom_range(0, 40 * 16) - 20 * 16;
			ey = sy + $urandom_range(0, 40 * 16) - 20 * 16;
			if ($urandom_range(0, 5) == 0)
				ex = sx;
			if ($urandom_range(0, 5) == 0)
				ey = sy;
			set_capsule(sx, sy, ex, ey, $urandom_range(0, 200), $urandom_range(0, 24'hFFFFFF));
			cx = (sx + ex) / 32;
			cy = (sy + ey) / 32;
			for (int i = 0; i < 30; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_pixel(make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom, $urandom, $urandom));
				else
					send_pixel(rand_pixel_near(cx, cy, 25));
			end
		end
		set_capsule($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4095),
			$urandom);
		for (int i = 0; i < 40; i++)
			send_pixel(make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom, $urandom, $urandom));
	endtask

	// Long output hold as pixels arrive, a pause until drained, then more pixels.
	task automatic test_backpressure();
		set_capsule(50 * 16, 50 * 16, 70 * 16, 60 * 16, 40, 24'hA0B0C0);
		hold_cycles = 120;
		hold_output = 1'b1;
		for (int i = 0; i < 80; i++)
			send_pixel(rand_pixel_near(60, 55, 12));
		pix_valid <= 1'b0;
		while (blend_queue.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 40; i++)
			send_pixel(rand_pixel_near(60, 55, 12));
	endtask

	// Final stretch with no idling on either side.
	task automatic test_full_rate();
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		set_capsule(20 * 16, 30 * 16, 40 * 16, 10 * 16, 64, 24'h7F7F7F);
		for (int i = 0; i < 60; i++)
			send_pixel(rand_pixel_near(30, 20, 20));
	endtask

	// Output stall generator: a long hold on request, otherwise short random bursts.
	always @(posedge clk) begin
		if (hold_output) begin
			res_stall <= 1'b1;
			if (hold_cycles == 0)
				hold_output <= 1'b0;
			else
				hold_cycles <= hold_cycles - 1;
		end else if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (receiver_idling && !res_stall && $urandom_range(0, 5) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (blend_queue.size() == 0) begin
				$error("unexpected result %h", res);
				error_count++;
			end else begin
				res_t exp_res;
				exp_res = blend_queue.pop_front();
				if (res.out_red !== exp_res.out_red) begin
					$error("out_red: expected %0d, actual %0d", exp_res.out_red, res.out_red);
					error_count++;
				end
				if (res.out_green !== exp_res.out_green) begin
					$error("out_green: expected %0d, actual %0d", exp_res.out_green,
						res.out_green);
					error_count++;
				end
				if (res.out_blue !== exp_res.out_blue) begin
					$error("out_blue: expected %0d, actual %0d", exp_res.out_blue,
						res.out_blue);
					error_count++;
				end
				if (res.coverage_alpha !== exp_res.coverage_alpha) begin
					$error("coverage_alpha: expected %0d, actual %0d",
						exp_res.coverage_alpha, res.coverage_alpha);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		seg_ax = '0;
		seg_ay = '0;
		seg_bx = '0;
		seg_by = '0;
		seg_radius = RW'(16);
		seg_fill = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_disc();
		test_directed();
		test_random_capsules();
		test_backpressure();
		test_full_rate();
		drain_pipe();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/acb_pkg.sv
rtl/acb_blend.sv
rtl/antialiased_capsule_blend_top.sv
bench/tb.sv
